// ===== src/igcd_pkg.sv =====
// ----------------------------------------------------------------------------
// igcd_pkg: shared types and constants
// Field widths, register indexes, opcodes and reset values of the gyro
// integrator and collision detector.
// ----------------------------------------------------------------------------
package igcd_pkg;

  localparam int RAW_W    = 16;
  localparam int RATE_W   = 24;
  localparam int OUT_W    = 48;
  localparam int HORIZ_W  = 14;
  localparam int GGAIN_W  = 8;
  localparam int AGAIN_W  = 16;
  localparam int GTHR_W   = 22;
  localparam int ATHR_W   = 14;
  localparam int CFG_W    = 22;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W     = 3;
  localparam int MUL_W    = 17;
  localparam int SQ_IN_W  = 32;
  localparam int SQ_OUT_W = 16;

  localparam int DEF_COUNT_BITS = 24;
  localparam int DEF_ACC_BITS   = 48;

  localparam logic [HORIZ_W-1:0]  HORIZ_MAX   = '1;
  localparam logic [GGAIN_W-1:0]  RST_GGAIN   = GGAIN_W'(70);
  localparam logic [AGAIN_W-1:0]  RST_AGAIN   = AGAIN_W'(15991);
  localparam logic [GTHR_W-1:0]   RST_GTHR    = GTHR_W'(500000);
  localparam logic [ATHR_W-1:0]   RST_ATHR    = ATHR_W'(400);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GGAIN = 2'd0,
    REG_AGAIN = 2'd1,
    REG_GTHR  = 2'd2,
    REG_ATHR  = 2'd3
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_GYRO      = 3'd0,
    OP_ACCEL     = 3'd1,
    OP_CAL_START = 3'd2,
    OP_CAL_END   = 3'd3,
    OP_ORIENT_CLR = 3'd4,
    OP_COLL_CLR  = 3'd5,
    OP_NOP6      = 3'd6,
    OP_NOP7      = 3'd7
  } op_t;

endpackage

// ===== src/igcd_div.sv =====
// ----------------------------------------------------------------------------
// igcd_div: restoring divider
// Unsigned quotient of a magnitude by a count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module igcd_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      // remainder stays below the divisor, so the low DEN_W bits carry it
      rem <= fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== src/igcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// igcd_sqrt: digit-by-digit integer square root
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module igcd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [igcd_pkg::SQ_IN_W-1:0]  val,
  output logic                          done,
  output logic [igcd_pkg::SQ_OUT_W-1:0] root
);
  import igcd_pkg::*;

  localparam int CNT_W = $clog2(SQ_OUT_W + 1);
  localparam int REM_W = SQ_OUT_W + 3;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SQ_IN_W-1:0] src;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   r_try;
  logic [REM_W-1:0]   trial;
  logic               fits;

  assign r_try = {rem[REM_W-3:0], src[SQ_IN_W-1 -: 2]};
  assign trial = REM_W'({root, 2'b01});
  assign fits  = r_try >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SQ_OUT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= val;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[SQ_IN_W-3:0], 2'b00};
      rem  <= fits ? r_try - trial : r_try;
      root <= {root[SQ_OUT_W-2:0], fits};
    end
  end

endmodule

// ===== src/imu_gyro_integrate_collision_detect.sv =====
// ----------------------------------------------------------------------------
// imu_gyro_integrate_collision_detect: gyro integrator and collision detector
// Integrates scaled gyro rates into orientation, gathers calibration sums,
// and flags collisions on yaw-rate or horizontal-acceleration jumps.
// ----------------------------------------------------------------------------
// Sequence: a gyro beat runs a multiply and an accumulate state per axis on
//   the shared multiplier; an accel beat runs multiply, square and sum for
//   the x and y axes, then 16 square-root steps; finish-cal runs one
//   restoring divide per axis; other commands pass through one command state.
// Throughput: one beat at a time; in_ready is high only while idle and the
//   result has been taken.
// Reset: rst clears the sequencer and block state and loads register defaults.
module imu_gyro_integrate_collision_detect #(
  parameter int COUNT_BITS = igcd_pkg::DEF_COUNT_BITS,
  parameter int ACC_BITS   = igcd_pkg::DEF_ACC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [igcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [igcd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [igcd_pkg::OP_W-1:0]           opcode,
  input  logic signed [igcd_pkg::RAW_W-1:0]   axis_x,
  input  logic signed [igcd_pkg::RAW_W-1:0]   axis_y,
  input  logic signed [igcd_pkg::RAW_W-1:0]   axis_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [igcd_pkg::OUT_W-1:0]   orient_x,
  output logic signed [igcd_pkg::OUT_W-1:0]   orient_y,
  output logic signed [igcd_pkg::OUT_W-1:0]   orient_z,
  output logic signed [igcd_pkg::RATE_W-1:0]  yaw_rate,
  output logic [igcd_pkg::HORIZ_W-1:0]        horiz_accel,
  output logic                                collision
);
  import igcd_pkg::*;

  localparam int PROD_W = 2 * MUL_W;
  localparam int DIFF_W = RATE_W + 1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_G_MUL  = 12'b0000_0000_0010,
    S_G_ACC  = 12'b0000_0000_0100,
    S_A_MUL  = 12'b0000_0000_1000,
    S_A_SQ   = 12'b0000_0001_0000,
    S_A_SUM  = 12'b0000_0010_0000,
    S_A_SQRT = 12'b0000_0100_0000,
    S_A_DONE = 12'b0000_1000_0000,
    S_C_DIV  = 12'b0001_0000_0000,
    S_C_WAIT = 12'b0010_0000_0000,
    S_CMD    = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [GGAIN_W-1:0] ggain;
  logic [AGAIN_W-1:0] again;
  logic [GTHR_W-1:0]  gthr;
  logic [ATHR_W-1:0]  athr;

  // latched beat
  op_t                     op;
  logic signed [RAW_W-1:0] ax [3];
  logic [1:0]              idx;

  // block state
  logic signed [ACC_BITS-1:0] orient [3];
  logic signed [ACC_BITS-1:0] cal    [3];
  logic signed [RATE_W-1:0]   offs   [3];
  logic [COUNT_BITS-1:0]      count;
  logic signed [RATE_W-1:0]   prev_yaw;
  logic [HORIZ_W-1:0]         prev_horiz;
  logic                       coll;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [SQ_IN_W-1:0] sumsq;

  logic signed [RAW_W-1:0] ax_sel;
  logic [MUL_W-1:0]        ax_abs;
  logic signed [RATE_W-1:0] rate;
  logic signed [DIFF_W-1:0] yaw_diff;
  logic [DIFF_W-1:0]        yaw_jump;

  logic                    sq_start, sq_done;
  logic [SQ_OUT_W-1:0]     sq_root;
  logic [HORIZ_W-1:0]      horiz;
  logic [HORIZ_W-1:0]      horiz_jump;

  logic                    dv_start, dv_done;
  logic [ACC_BITS-1:0]     dv_num, dv_quo;
  logic                    cal_neg;
  logic signed [RATE_W-1:0] offs_new;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [DIFF_W-1:0]   b
  );
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(b);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // select the working axis and take its magnitude
  assign ax_sel = ax[idx];
  assign ax_abs = ax_sel[RAW_W-1] ? MUL_W'(-{ax_sel[RAW_W-1], ax_sel})
                                  : MUL_W'(ax_sel);

  always_comb begin
    mul_a = ax_abs;
    mul_b = MUL_W'(ggain);
    if (state == S_A_MUL) begin
      mul_b = MUL_W'(again);
    end else if (state == S_A_SQ) begin
      mul_a = prod[AGAIN_W +: MUL_W];
      mul_b = prod[AGAIN_W +: MUL_W];
    end
  end

  // rate magnitude fits 23 bits; restore the sign
  assign rate = ax_sel[RAW_W-1] ? -RATE_W'(prod) : RATE_W'(prod);
  assign yaw_diff = DIFF_W'(rate) - DIFF_W'(prev_yaw);
  assign yaw_jump = yaw_diff[DIFF_W-1] ? -yaw_diff : yaw_diff;

  assign horiz = (sq_root > SQ_OUT_W'(HORIZ_MAX)) ? HORIZ_MAX : sq_root[HORIZ_W-1:0];
  assign horiz_jump = (horiz > prev_horiz) ? horiz - prev_horiz : prev_horiz - horiz;

  assign sq_start = (state == S_A_SQRT);
  assign dv_start = (state == S_C_DIV);
  assign cal_neg  = cal[idx][ACC_BITS-1];
  assign dv_num   = cal_neg ? -cal[idx] : cal[idx];

  // sign and clamp the quotient to the offset range
  always_comb begin
    if (count == '0) begin
      offs_new = '0;
    end else if (cal_neg) begin
      if (dv_quo > ACC_BITS'(1 << (RATE_W-1))) offs_new = {1'b1, {(RATE_W-1){1'b0}}};
      else offs_new = -RATE_W'(dv_quo);
    end else begin
      if (dv_quo > ACC_BITS'((1 << (RATE_W-1)) - 1)) offs_new = {1'b0, {(RATE_W-1){1'b1}}};
      else offs_new = RATE_W'(dv_quo);
    end
  end

  igcd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sumsq),
    .done  (sq_done),
    .root  (sq_root)
  );

  igcd_div #(
    .NUM_W (ACC_BITS),
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (count),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(opcode))
            OP_GYRO:  state_next = S_G_MUL;
            OP_ACCEL: state_next = S_A_MUL;
            OP_CAL_END: state_next = S_C_DIV;
            default:  state_next = S_CMD;
          endcase
        end
      end
      S_G_MUL:  state_next = S_G_ACC;
      S_G_ACC:  state_next = (idx == 2'd2) ? S_OUT : S_G_MUL;
      S_A_MUL:  state_next = S_A_SQ;
      S_A_SQ:   state_next = S_A_SUM;
      S_A_SUM:  state_next = (idx == 2'd1) ? S_A_SQRT : S_A_MUL;
      S_A_SQRT: state_next = S_A_DONE;
      S_A_DONE: if (sq_done) state_next = S_OUT;
      S_C_DIV:  state_next = S_C_WAIT;
      S_C_WAIT: if (dv_done) state_next = (idx == 2'd2) ? S_OUT : S_C_DIV;
      S_CMD:    state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ggain <= RST_GGAIN;
      again <= RST_AGAIN;
      gthr  <= RST_GTHR;
      athr  <= RST_ATHR;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GGAIN: ggain <= cfg_data[GGAIN_W-1:0];
        REG_AGAIN: again <= cfg_data[AGAIN_W-1:0];
        REG_GTHR:  gthr  <= cfg_data[GTHR_W-1:0];
        REG_ATHR:  athr  <= cfg_data[ATHR_W-1:0];
        default: ;
      endcase
    end
  end

  // latch the beat and run the multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == S_IDLE && in_valid) begin
      op    <= op_t'(opcode);
      ax[0] <= axis_x;
      ax[1] <= axis_y;
      ax[2] <= axis_z;
    end
    if (state == S_A_SUM) begin
      sumsq <= (idx == 2'd0) ? SQ_IN_W'(prod) : sumsq + SQ_IN_W'(prod);
    end
  end

  // block state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      count      <= '0;
      prev_yaw   <= '0;
      prev_horiz <= '0;
      coll       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        orient[i] <= '0;
        cal[i]    <= '0;
        offs[i]   <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: idx <= '0;
        S_G_ACC: begin
          orient[idx] <= sat_add(orient[idx], DIFF_W'(rate) - DIFF_W'(offs[idx]));
          cal[idx]    <= sat_add(cal[idx], DIFF_W'(rate));
          idx         <= idx + 2'd1;
          if (idx == 2'd2) begin
            // yaw jump uses the raw rate, not the offset-corrected one
            if (yaw_jump > DIFF_W'(gthr)) coll <= 1'b1;
            prev_yaw <= rate;
            if (count != '1) count <= count + COUNT_BITS'(1);
          end
        end
        S_A_SUM: idx <= idx + 2'd1;
        S_A_DONE: begin
          if (sq_done) begin
            if (horiz_jump > athr) coll <= 1'b1;
            prev_horiz <= horiz;
          end
        end
        S_C_WAIT: begin
          if (dv_done) begin
            offs[idx]   <= offs_new;
            orient[idx] <= '0;
            idx         <= idx + 2'd1;
          end
        end
        S_CMD: begin
          unique case (op)
            OP_CAL_START: begin
              count <= '0;
              for (int i = 0; i < 3; i++) begin
                cal[i]  <= '0;
                offs[i] <= '0;
              end
            end
            OP_ORIENT_CLR: begin
              for (int i = 0; i < 3; i++) orient[i] <= '0;
            end
            OP_COLL_CLR: coll <= 1'b0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // result fields show state after the beat
  assign orient_x    = OUT_W'(orient[0]);
  assign orient_y    = OUT_W'(orient[1]);
  assign orient_z    = OUT_W'(orient[2]);
  assign yaw_rate    = prev_yaw;
  assign horiz_accel = prev_horiz;
  assign collision   = coll;

endmodule

// ===== src/igcd_checker.sv =====
// ----------------------------------------------------------------------------
// igcd_checker: port-level checks
// Handshake and sequencing checks seen at the top-level ports.
// ----------------------------------------------------------------------------
module igcd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [igcd_pkg::OUT_W-1:0]   orient_z,
  input logic                                collision
);
  import igcd_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && !out_valid)
    else $error("block not busy after input beat");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid && in_ready)
    else $error("block not idle after result beat");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(orient_z) && $stable(collision))
    else $error("stalled result changed");

endmodule

bind imu_gyro_integrate_collision_detect igcd_checker u_igcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .orient_z  (orient_z),
  .collision (collision)
);
